FILE: sv/c8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types, opcode constants and the hex glyph table of the CHIP-8 core.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int unsigned SCR_W = 64;
  localparam int unsigned SCR_H = 32;
  localparam int unsigned ROW_W = $clog2(SCR_H);
  localparam int unsigned COL_W = $clog2(SCR_W);

  localparam logic [11:0] START_RESET = 12'd512;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_EXEC = 2'd1,
    CMD_TICK = 2'd2,
    CMD_READ = 2'd3
  } cmd_e;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [7:0] NN_SKP   = 8'h9E;
  localparam logic [7:0] NN_SKNP  = 8'hA1;
  localparam logic [7:0] NN_GETDT = 8'h07;
  localparam logic [7:0] NN_WAITK = 8'h0A;
  localparam logic [7:0] NN_SETDT = 8'h15;
  localparam logic [7:0] NN_SETST = 8'h18;
  localparam logic [7:0] NN_ADDI  = 8'h1E;
  localparam logic [7:0] NN_FONT  = 8'h29;
  localparam logic [7:0] NN_BCD   = 8'h33;
  localparam logic [7:0] NN_STORE = 8'h55;
  localparam logic [7:0] NN_LOAD  = 8'h65;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam int unsigned FONT_BYTES = 80;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage

FILE: sv/chip8_interpreter_core.sv
`timescale 1ns / 1ps
// Throughput: one item at a time; the single byte memory port sets the pace.
// Reset: asynchronous; a clearing pass over all MEMORY_BYTES addresses loads the
//   glyphs and zeroes the rest of memory, with input stalled meanwhile.
// ----------------------------------------------------------------------------
// chip8_interpreter_core
// CHIP-8 processor: byte memory, V registers, screen and return stack in
// synchronous memories, driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
module chip8_interpreter_core
  import c8_pkg::*;
#(
  parameter int unsigned MEMORY_BYTES = 4096,
  parameter int unsigned STACK_DEPTH  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [11:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [11:0]          load_address_i,
  input  logic [7:0]           load_byte_i,
  input  logic [15:0]          key_mask_i,
  input  logic [7:0]           random_byte_i,
  input  logic [ROW_W-1:0]     screen_row_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [11:0]          next_pc_o,
  output logic [15:0]          fetched_opcode_o,
  output logic [SCR_W-1:0]     row_pixels_o,
  output logic                 waiting_for_key_o,
  output logic                 sound_on_o,
  output logic                 stack_fault_o
);

  localparam int unsigned MAW = $clog2(MEMORY_BYTES);
  localparam int unsigned AW  = 17;
  localparam int unsigned QW  = AW + 1 - MAW;
  localparam int unsigned XW  = AW + QW;
  localparam int unsigned KW  = $clog2(QW + 1);
  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_MOD  = 5'd2;
  localparam logic [4:0] S_LOAD = 5'd3;
  localparam logic [4:0] S_FH   = 5'd4;
  localparam logic [4:0] S_FL   = 5'd5;
  localparam logic [4:0] S_FC   = 5'd6;
  localparam logic [4:0] S_VX   = 5'd7;
  localparam logic [4:0] S_VY   = 5'd8;
  localparam logic [4:0] S_EX   = 5'd9;
  localparam logic [4:0] S_RET  = 5'd10;
  localparam logic [4:0] S_WRF  = 5'd11;
  localparam logic [4:0] S_D0   = 5'd12;
  localparam logic [4:0] S_D1   = 5'd13;
  localparam logic [4:0] S_D2   = 5'd14;
  localparam logic [4:0] S_BCD  = 5'd15;
  localparam logic [4:0] S_ST0  = 5'd16;
  localparam logic [4:0] S_ST1  = 5'd17;
  localparam logic [4:0] S_LD0  = 5'd18;
  localparam logic [4:0] S_LD1  = 5'd19;
  localparam logic [4:0] S_SCR  = 5'd20;
  localparam logic [4:0] S_RES  = 5'd21;

  // memories
  logic [7:0]       mem [MEMORY_BYTES];
  logic [7:0]       vmem [16];
  logic [15:0]      vvalid_q;
  logic [SCR_W-1:0] smem [SCR_H];
  logic [SCR_H-1:0] svalid_q;
  logic [11:0]      stk [STACK_DEPTH];

  logic [4:0]       state_q, ret_q;
  logic [1:0]       cmd_q;
  logic [15:0]      keys_q;
  logic [7:0]       rnd_q, ldb_q, hi_q, vx_q, vy_q, spr_q, dt_q, st_q;
  logic [15:0]      op_q, i_q;
  logic [11:0]      pc_q;
  logic [SPW-1:0]   sp_q;
  logic             wait_q, fault_q, flag_q, coll_q, out_valid_q;
  logic [3:0]       r_q;
  logic [AW-1:0]    mv_q;
  logic [KW-1:0]    k_q;
  logic [MAW-1:0]   base_q, clr_q;
  logic [7:0]       mem_q, vmem_q;
  logic             vval_q, sval_q;
  logic [SCR_W-1:0] smem_q, row_q;
  logic [11:0]      stk_q;
  logic [11:0]      pc_o_q;
  logic [15:0]      op_o_q;
  logic [SCR_W-1:0] row_o_q;
  logic             wait_o_q, snd_o_q, fault_o_q;

  logic             acc;
  logic             mem_we, v_we, s_we, stk_we;
  logic [MAW-1:0]   mem_addr, aoff;
  logic [7:0]       mem_wd, v_wd, vrd;
  logic [3:0]       v_addr, off, xi, nib;
  logic [ROW_W-1:0] s_addr, drow;
  logic [SCR_W-1:0] s_wd, scr_rd, mask;
  logic [SIW-1:0]   stk_addr;
  logic [MAW:0]     asum;
  logic [XW-1:0]    mvx, msh;
  logic [7:0]       nn, alu_v, bcd_d, lowkey;
  logic             alu_f, alu_fw, key_dn, any_key;
  logic [1:0]       hund;
  logic [6:0]       rem;
  logic [14:0]      tprod;
  logic [3:0]       tens, units;
  logic [2*SCR_W-1:0] rot;

  assign in_stall_o = !(state_q == S_IDLE && !out_valid_q);
  assign acc        = in_valid_i && !in_stall_o;

  assign nn     = op_q[7:0];
  assign xi     = op_q[11:8];
  assign nib    = op_q[3:0];
  assign vrd    = vval_q ? vmem_q : 8'd0;
  assign scr_rd = sval_q ? smem_q : '0;
  assign key_dn = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
  assign any_key = |keys_q;

  // address base plus offset, wrapped into memory
  assign off  = (state_q == S_FL) ? 4'd1 : r_q;
  assign asum = {1'b0, base_q} + (MAW+1)'(off);
  assign aoff = (asum >= (MAW+1)'(MEMORY_BYTES)) ?
                MAW'(asum - (MAW+1)'(MEMORY_BYTES)) : asum[MAW-1:0];

  assign mvx = XW'(mv_q);
  assign msh = XW'(MEMORY_BYTES) << k_q;

  assign drow = vy_q[ROW_W-1:0] + ROW_W'(r_q);
  assign rot  = {spr_q, {(SCR_W-8){1'b0}}, spr_q, {(SCR_W-8){1'b0}}}
                >> vx_q[COL_W-1:0];
  assign mask = rot[SCR_W-1:0];

  // decimal digits
  assign hund  = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
  assign rem   = 7'(vx_q - 8'(hund) * 8'd100);
  assign tprod = 15'(rem) * 15'd205;
  assign tens  = 4'(tprod >> 11);
  assign units = 4'(rem - 7'(tens) * 7'd10);
  always_comb begin
    case (r_q)
      4'd0:    bcd_d = 8'(hund);
      4'd1:    bcd_d = 8'(tens);
      default: bcd_d = 8'(units);
    endcase
  end

  always_comb begin
    lowkey = 8'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) lowkey = 8'(k);
    end
  end

  always_comb begin
    alu_f  = 1'b0;
    alu_fw = 1'b0;
    case (nib)
      ALU_MOV: alu_v = vy_q;
      ALU_OR:  alu_v = vx_q | vy_q;
      ALU_AND: alu_v = vx_q & vy_q;
      ALU_XOR: alu_v = vx_q ^ vy_q;
      ALU_ADD: begin
        alu_v  = vx_q + vy_q;
        alu_f  = (9'(vx_q) + 9'(vy_q)) > 9'd255;
        alu_fw = 1'b1;
      end
      ALU_SUB: begin
        alu_v  = vx_q - vy_q;
        alu_f  = vx_q >= vy_q;
        alu_fw = 1'b1;
      end
      ALU_SHR: begin
        alu_v  = vy_q >> 1;
        alu_f  = vy_q[0];
        alu_fw = 1'b1;
      end
      ALU_SBN: begin
        alu_v  = vy_q - vx_q;
        alu_f  = vy_q >= vx_q;
        alu_fw = 1'b1;
      end
      ALU_SHL: begin
        alu_v  = vy_q << 1;
        alu_f  = vy_q[7];
        alu_fw = 1'b1;
      end
      default: alu_v = vx_q;
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = base_q;
    mem_wd   = vrd;
    v_we     = 1'b0;
    v_addr   = xi;
    v_wd     = alu_v;
    s_we     = 1'b0;
    s_addr   = drow;
    s_wd     = scr_rd ^ mask;
    stk_we   = 1'b0;
    stk_addr = sp_q[SIW-1:0];
    case (state_q)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        mem_wd   = (clr_q < MAW'(FONT_BYTES)) ? FONT[7'(clr_q)] : 8'd0;
      end
      S_IDLE: s_addr = screen_row_i;
      S_LOAD: begin
        mem_we = 1'b1;
        mem_wd = ldb_q;
      end
      S_FL, S_D0, S_LD0: mem_addr = aoff;
      S_FC: v_addr = hi_q[3:0];
      S_VX: v_addr = op_q[7:4];
      S_EX: begin
        case (op_q[15:12])
          4'h0: stk_addr = SIW'(sp_q - SPW'(1));
          4'h2: stk_we = (sp_q < SPW'(STACK_DEPTH));
          4'h6: begin
            v_we = 1'b1;
            v_wd = nn;
          end
          4'h7: begin
            v_we = 1'b1;
            v_wd = vx_q + nn;
          end
          4'h8: v_we = (nib <= ALU_SBN) || (nib == ALU_SHL);
          4'hC: begin
            v_we = 1'b1;
            v_wd = rnd_q & nn;
          end
          4'hF: begin
            case (nn)
              NN_GETDT: begin
                v_we = 1'b1;
                v_wd = dt_q;
              end
              NN_WAITK: begin
                v_we = any_key;
                v_wd = lowkey;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_WRF: begin
        v_we   = 1'b1;
        v_addr = 4'hF;
        v_wd   = {7'd0, flag_q};
      end
      S_D2: s_we = 1'b1;
      S_BCD: begin
        mem_we   = 1'b1;
        mem_addr = aoff;
        mem_wd   = bcd_d;
      end
      S_ST0: v_addr = r_q;
      S_ST1: begin
        mem_we   = 1'b1;
        mem_addr = aoff;
      end
      S_LD1: begin
        v_we   = 1'b1;
        v_addr = r_q;
        v_wd   = mem_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q <= mem[mem_addr];
    if (v_we) begin
      vmem[v_addr] <= v_wd;
    end
    vmem_q <= vmem[v_addr];
    if (s_we) begin
      smem[s_addr] <= s_wd;
    end
    smem_q <= smem[s_addr];
    if (stk_we) begin
      stk[stk_addr] <= pc_q;
    end
    stk_q <= stk[stk_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vvalid_q <= '0;
      vval_q   <= 1'b0;
      svalid_q <= '0;
      sval_q   <= 1'b0;
    end else begin
      vval_q <= vvalid_q[v_addr];
      sval_q <= svalid_q[s_addr];
      if (v_we) begin
        vvalid_q[v_addr] <= 1'b1;
      end
      if (state_q == S_EX && op_q == OP_CLS) begin
        svalid_q <= '0;
      end else if (s_we) begin
        svalid_q[s_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q  <= command_i;
      keys_q <= key_mask_i;
      rnd_q  <= random_byte_i;
      ldb_q  <= load_byte_i;
    end
    if (state_q == S_FL) begin
      hi_q <= mem_q;
    end
    if (state_q == S_VX) begin
      vx_q <= vrd;
    end
    if (state_q == S_VY) begin
      vy_q <= vrd;
    end
    if (state_q == S_D1) begin
      spr_q <= mem_q;
    end
    if (state_q == S_SCR) begin
      row_q <= scr_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ret_q       <= S_IDLE;
      clr_q       <= '0;
      op_q        <= '0;
      pc_q        <= START_RESET;
      i_q         <= '0;
      sp_q        <= '0;
      dt_q        <= '0;
      st_q        <= '0;
      wait_q      <= 1'b0;
      fault_q     <= 1'b0;
      flag_q      <= 1'b0;
      coll_q      <= 1'b0;
      r_q         <= '0;
      mv_q        <= '0;
      k_q         <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      pc_o_q      <= '0;
      op_o_q      <= '0;
      row_o_q     <= '0;
      wait_o_q    <= 1'b0;
      snd_o_q     <= 1'b0;
      fault_o_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + MAW'(1);
          if (clr_q == MAW'(MEMORY_BYTES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            wait_q  <= 1'b0;
            fault_q <= 1'b0;
            r_q     <= '0;
            op_q    <= '0;
            k_q     <= KW'(QW - 1);
            case (command_i)
              CMD_LOAD: begin
                mv_q    <= AW'(load_address_i);
                ret_q   <= S_LOAD;
                state_q <= S_MOD;
              end
              CMD_EXEC: begin
                mv_q    <= AW'(pc_q);
                ret_q   <= S_FH;
                state_q <= S_MOD;
              end
              CMD_TICK: begin
                if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
                if (st_q != 8'd0) st_q <= st_q - 8'd1;
                state_q <= S_RES;
              end
              default: state_q <= S_SCR;
            endcase
          end
        end
        S_MOD: begin
          if (mvx >= msh) begin
            mv_q <= AW'(mvx - msh);
          end
          k_q <= k_q - KW'(1);
          if (k_q == '0) begin
            base_q  <= (mvx >= msh) ? MAW'(mvx - msh) : mv_q[MAW-1:0];
            state_q <= ret_q;
          end
        end
        S_LOAD: state_q <= S_RES;
        S_FH:   state_q <= S_FL;
        S_FL:   state_q <= S_FC;
        S_FC: begin
          op_q    <= {hi_q, mem_q};
          pc_q    <= pc_q + 12'd2;
          state_q <= S_VX;
        end
        S_VX: state_q <= S_VY;
        S_VY: state_q <= S_EX;
        S_EX: begin
          state_q <= S_RES;
          k_q     <= KW'(QW - 1);
          mv_q    <= AW'(i_q);
          r_q     <= '0;
          coll_q  <= 1'b0;
          case (op_q[15:12])
            4'h0: begin
              if (op_q == OP_RET) begin
                if (sp_q == '0) begin
                  fault_q <= 1'b1;
                end else begin
                  sp_q    <= sp_q - SPW'(1);
                  state_q <= S_RET;
                end
              end
            end
            4'h1: pc_q <= op_q[11:0];
            4'h2: begin
              if (sp_q >= SPW'(STACK_DEPTH)) begin
                fault_q <= 1'b1;
              end else begin
                sp_q <= sp_q + SPW'(1);
                pc_q <= op_q[11:0];
              end
            end
            4'h3: if (vx_q == nn) pc_q <= pc_q + 12'd2;
            4'h4: if (vx_q != nn) pc_q <= pc_q + 12'd2;
            4'h5: if (vx_q == vy_q) pc_q <= pc_q + 12'd2;
            4'h8: begin
              if (alu_fw) begin
                flag_q  <= alu_f;
                state_q <= S_WRF;
              end
            end
            4'h9: if (vx_q != vy_q) pc_q <= pc_q + 12'd2;
            4'hA: i_q <= {4'd0, op_q[11:0]};
            4'hD: begin
              if (nib == 4'd0) begin
                flag_q  <= 1'b0;
                state_q <= S_WRF;
              end else begin
                ret_q   <= S_D0;
                state_q <= S_MOD;
              end
            end
            4'hE: begin
              if ((nn == NN_SKP && key_dn) || (nn == NN_SKNP && !key_dn)) begin
                pc_q <= pc_q + 12'd2;
              end
            end
            4'hF: begin
              case (nn)
                NN_WAITK: begin
                  if (!any_key) begin
                    pc_q   <= pc_q - 12'd2;
                    wait_q <= 1'b1;
                  end
                end
                NN_SETDT: dt_q <= vx_q;
                NN_SETST: st_q <= vx_q;
                NN_ADDI:  i_q <= i_q + 16'(vx_q);
                NN_FONT:  i_q <= 16'(vx_q[3:0]) * 16'd5;
                NN_BCD: begin
                  ret_q   <= S_BCD;
                  state_q <= S_MOD;
                end
                NN_STORE: begin
                  ret_q   <= S_ST0;
                  state_q <= S_MOD;
                end
                NN_LOAD: begin
                  ret_q   <= S_LD0;
                  state_q <= S_MOD;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_RET: begin
          pc_q    <= stk_q;
          state_q <= S_RES;
        end
        S_WRF: state_q <= S_RES;
        S_D0:  state_q <= S_D1;
        S_D1:  state_q <= S_D2;
        S_D2: begin
          if (r_q == nib - 4'd1) begin
            flag_q  <= coll_q || ((scr_rd & mask) != '0);
            state_q <= S_WRF;
          end else begin
            coll_q  <= coll_q || ((scr_rd & mask) != '0);
            r_q     <= r_q + 4'd1;
            state_q <= S_D0;
          end
        end
        S_BCD: begin
          r_q <= r_q + 4'd1;
          if (r_q == 4'd2) state_q <= S_RES;
        end
        S_ST0: state_q <= S_ST1;
        S_ST1: begin
          r_q <= r_q + 4'd1;
          state_q <= (r_q == xi) ? S_RES : S_ST0;
        end
        S_LD0: state_q <= S_LD1;
        S_LD1: begin
          r_q <= r_q + 4'd1;
          state_q <= (r_q == xi) ? S_RES : S_LD0;
        end
        S_SCR: state_q <= S_RES;
        S_RES: begin
          out_valid_q <= 1'b1;
          pc_o_q      <= pc_q;
          op_o_q      <= (cmd_q == CMD_EXEC) ? op_q : 16'd0;
          row_o_q     <= (cmd_q == CMD_READ) ? row_q : '0;
          wait_o_q    <= wait_q;
          snd_o_q     <= (st_q != 8'd0);
          fault_o_q   <= fault_q;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign next_pc_o         = pc_o_q;
  assign fetched_opcode_o  = op_o_q;
  assign row_pixels_o      = row_o_q;
  assign waiting_for_key_o = wait_o_q;
  assign sound_on_o        = snd_o_q;
  assign stack_fault_o     = fault_o_q;

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> in_stall_o)
    else $error("second beat taken while busy");

  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && k_q == '0) |=>
      ({1'b0, base_q} < (MAW+1)'(MEMORY_BYTES)))
    else $error("reduced address out of range");
`endif

endmodule
